### rtl/rfsn_pkg.sv
// Shared types, constants and helpers for the radius filter neighbor search.
// Used by every module under rtl; depends on nothing.
package rfsn_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int COORD_W = 20;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DIST_W  = 42;
    localparam int DLO_W   = DIST_W / 2;
    localparam int DHI_W   = DIST_W - DLO_W;
    localparam int SLOT_W  = 5;
    localparam int DIR_W   = 16;
    localparam int MAG_W   = 15;
    localparam int UNIT    = 16384;
    localparam int KK_W    = 2 * MAG_W;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int RHS_SH  = 30;
    localparam int CMP_W   = KK_W + DIST_W;
    localparam int PART_W  = KK_W + DHI_W;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SRD, ST_SDIF, ST_SMX, ST_SMY, ST_SMZ, ST_SACC, ST_SCMP,
        ST_SEL0, ST_QRD, ST_QCMP, ST_PRD, ST_PDIF, ST_C2, ST_C2W,
        ST_IT, ST_K2, ST_KL, ST_KH, ST_OUT
    } t_state;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

### rtl/rfsn_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on rfsn_pkg.
module rfsn_mul
    import rfsn_pkg::*;
(
    input  logic              i_clk,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);
    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;
endmodule

### rtl/rfsn_pmem.sv
// Point list storage: one write port, one registered read port.
// Depends on rfsn_pkg.
module rfsn_pmem
    import rfsn_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [IDX_W-1:0]          i_waddr,
    input  logic signed [COORD_W-1:0] i_wx,
    input  logic signed [COORD_W-1:0] i_wy,
    input  logic signed [COORD_W-1:0] i_wz,
    input  logic                      i_wpres,
    input  logic [IDX_W-1:0]          i_raddr,
    output logic signed [COORD_W-1:0] o_rx,
    output logic signed [COORD_W-1:0] o_ry,
    output logic signed [COORD_W-1:0] o_rz,
    output logic                      o_rpres
);
    logic [3*COORD_W:0] mem [ENTRIES];
    logic [3*COORD_W:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wpres, i_wx, i_wy, i_wz};
        end
        r_rd <= mem[i_raddr];
    end

    assign o_rpres = r_rd[3*COORD_W];
    assign o_rx    = r_rd[3*COORD_W-1:2*COORD_W];
    assign o_ry    = r_rd[2*COORD_W-1:COORD_W];
    assign o_rz    = r_rd[COORD_W-1:0];
endmodule

### rtl/radius_filter_sorted_neighbors_top.sv
// Top level of the radius filter neighbor search: sequencer, distance store.
// Depends on rfsn_pkg, rfsn_mul and rfsn_pmem.
//
// Clear and append are handled while idle, so input stays ready. A query over N
// stored points first scans them all, then for each of M matches picks the
// next nearest one, normalizes its direction and presents it, all on one
// shared 32x32 multiplier. Input is not ready while a query runs, and
// each result waits in the output register until it is taken.
module radius_filter_sorted_neighbors_top
    import rfsn_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [CMD_W-1:0]          i_command,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic                      i_present,
    input  logic [DIST_W-1:0]         i_radius_sq,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_found,
    output logic [SLOT_W-1:0]         o_slot,
    output logic [DIST_W-1:0]         o_dist_sq,
    output logic signed [DIR_W-1:0]   o_dir_x,
    output logic signed [DIR_W-1:0]   o_dir_y,
    output logic signed [DIR_W-1:0]   o_dir_z,
    output logic                      o_last
);
    t_state r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_nmatch, n_nmatch;
    logic [ENTRIES-1:0] r_match, n_match;
    logic [IDX_W-1:0]   r_idx, n_idx;

    logic signed [COORD_W-1:0] r_ox, r_oy, r_oz, n_ox, n_oy, n_oz;
    logic [DIST_W-1:0]  r_rad, n_rad;
    logic [DIFF_W-1:0]  r_c [3];
    logic [DIFF_W-1:0]  n_c [3];
    logic [2:0]         r_neg, n_neg;
    logic [DIST_W-1:0]  r_acc, n_acc;
    logic               r_best_v, n_best_v;
    logic [IDX_W-1:0]   r_best, n_best;
    logic [DIST_W-1:0]  r_best_d, n_best_d;
    logic [DIST_W-1:0]  r_dsel, n_dsel;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic               r_found, n_found;
    logic               r_last, n_last;
    logic [1:0]         r_comp, n_comp;
    logic signed [DIR_W-1:0] r_dir [3];
    logic signed [DIR_W-1:0] n_dir [3];
    logic [CMP_W-1:0]   r_rhs, n_rhs;
    logic [MAG_W-1:0]   r_lo, r_hi, r_n, n_lo, n_hi, n_n;
    logic [KK_W-1:0]    r_kk, n_kk;
    logic [PART_W-1:0]  r_plo, n_plo;

    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p;

    logic               pm_we;
    logic signed [COORD_W-1:0] pm_x, pm_y, pm_z;
    logic               pm_pres;

    logic               dm_we;
    logic [DIST_W-1:0]  dmem [ENTRIES];
    logic [DIST_W-1:0]  r_drd;

    logic               in_xfer;
    logic [MAG_W:0]     mid_sum;
    logic [MAG_W-1:0]   mid;
    logic [MAG_W-1:0]   k;
    logic [CMP_W-1:0]   prod;
    logic [DIFF_W-1:0]  cur_c;

    rfsn_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    rfsn_pmem u_pmem (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wx    (i_pos_x),
        .i_wy    (i_pos_y),
        .i_wz    (i_pos_z),
        .i_wpres (i_present),
        .i_raddr (r_idx),
        .o_rx    (pm_x),
        .o_ry    (pm_y),
        .o_rz    (pm_z),
        .o_rpres (pm_pres)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign in_xfer = i_valid && o_ready;
    assign pm_we   = in_xfer && (t_cmd'(i_command) == CMD_APPEND)
                     && (r_count < CNT_W'(ENTRIES));

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + (MAG_W+1)'(1);
    assign mid     = mid_sum[MAG_W:1];
    assign k       = MAG_W'({mid, 1'b0} - (MAG_W+1)'(1));
    assign prod    = {mul_p[PART_W-1:0], {DLO_W{1'b0}}} + CMP_W'(r_plo);
    assign cur_c   = r_c[r_comp];

    // distance store, indexed by slot
    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dmem[r_idx] <= r_acc;
        end
        r_drd <= dmem[r_idx];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_nmatch = r_nmatch;
        n_match  = r_match;
        n_idx    = r_idx;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_oz     = r_oz;
        n_rad    = r_rad;
        n_c      = r_c;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_best_v = r_best_v;
        n_best   = r_best;
        n_best_d = r_best_d;
        n_dsel   = r_dsel;
        n_slot   = r_slot;
        n_found  = r_found;
        n_last   = r_last;
        n_comp   = r_comp;
        n_dir    = r_dir;
        n_rhs    = r_rhs;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_n      = r_n;
        n_kk     = r_kk;
        n_plo    = r_plo;
        mul_a    = '0;
        mul_b    = '0;
        dm_we    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (t_cmd'(i_command))
                        CMD_CLEAR:  n_count = '0;
                        CMD_APPEND: begin
                            if (pm_we) begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            n_ox     = i_pos_x;
                            n_oy     = i_pos_y;
                            n_oz     = i_pos_z;
                            n_rad    = i_radius_sq;
                            n_match  = '0;
                            n_nmatch = '0;
                            n_idx    = '0;
                            n_state  = (r_count == '0) ? ST_SEL0 : ST_SRD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRD: n_state = ST_SDIF;
            ST_SDIF: begin
                n_c[0]  = abs_diff(pm_x, r_ox);
                n_c[1]  = abs_diff(pm_y, r_oy);
                n_c[2]  = abs_diff(pm_z, r_oz);
                n_state = ST_SMX;
            end
            ST_SMX: begin
                mul_a   = MUL_W'(r_c[0]);
                mul_b   = MUL_W'(r_c[0]);
                n_state = ST_SMY;
            end
            ST_SMY: begin
                n_acc   = mul_p[DIST_W-1:0];
                mul_a   = MUL_W'(r_c[1]);
                mul_b   = MUL_W'(r_c[1]);
                n_state = ST_SMZ;
            end
            ST_SMZ: begin
                n_acc   = r_acc + mul_p[DIST_W-1:0];
                mul_a   = MUL_W'(r_c[2]);
                mul_b   = MUL_W'(r_c[2]);
                n_state = ST_SACC;
            end
            ST_SACC: begin
                n_acc   = r_acc + mul_p[DIST_W-1:0];
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                if (pm_pres && (r_acc <= r_rad)) begin
                    dm_we          = 1'b1;
                    n_match[r_idx] = 1'b1;
                    n_nmatch       = r_nmatch + CNT_W'(1);
                end
                if (CNT_W'(r_idx) == r_count - CNT_W'(1)) begin
                    n_state = ST_SEL0;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_SRD;
                end
            end
            ST_SEL0: begin
                if (r_nmatch == '0) begin
                    // empty query: one result with found clear
                    n_found  = 1'b0;
                    n_last   = 1'b1;
                    n_slot   = '0;
                    n_dsel   = '0;
                    n_dir[0] = '0;
                    n_dir[1] = '0;
                    n_dir[2] = '0;
                    n_state  = ST_OUT;
                end else begin
                    n_idx    = '0;
                    n_best_v = 1'b0;
                    n_state  = ST_QRD;
                end
            end
            ST_QRD: n_state = ST_QCMP;
            ST_QCMP: begin
                // strict compare keeps the lower slot on a tie
                if (r_match[r_idx] && (!r_best_v || (r_drd < r_best_d))) begin
                    n_best_v = 1'b1;
                    n_best   = r_idx;
                    n_best_d = r_drd;
                end
                if (CNT_W'(r_idx) == r_count - CNT_W'(1)) begin
                    n_idx   = n_best;
                    n_state = ST_PRD;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_QRD;
                end
            end
            ST_PRD: begin
                n_match[r_best] = 1'b0;
                n_nmatch        = r_nmatch - CNT_W'(1);
                n_last          = (r_nmatch == CNT_W'(1));
                n_found         = 1'b1;
                n_slot          = r_best;
                n_dsel          = r_best_d;
                n_state         = ST_PDIF;
            end
            ST_PDIF: begin
                n_c[0]   = abs_diff(pm_x, r_ox);
                n_c[1]   = abs_diff(pm_y, r_oy);
                n_c[2]   = abs_diff(pm_z, r_oz);
                n_neg[0] = (pm_x < r_ox);
                n_neg[1] = (pm_y < r_oy);
                n_neg[2] = (pm_z < r_oz);
                n_comp   = '0;
                n_state  = ST_C2;
            end
            ST_C2: begin
                if (r_dsel == '0) begin
                    n_dir[r_comp] = '0;
                    if (r_comp == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_comp = r_comp + 2'd1;
                    end
                end else begin
                    mul_a   = MUL_W'(cur_c);
                    mul_b   = MUL_W'(cur_c);
                    n_state = ST_C2W;
                end
            end
            ST_C2W: begin
                n_rhs   = {mul_p[CMP_W-RHS_SH-1:0], {RHS_SH{1'b0}}};
                n_lo    = '0;
                n_hi    = MAG_W'(UNIT);
                n_state = ST_IT;
            end
            ST_IT: begin
                if (r_lo == r_hi) begin
                    n_dir[r_comp] = r_neg[r_comp] ? DIR_W'(-$signed({1'b0, r_lo}))
                                                  : DIR_W'({1'b0, r_lo});
                    if (r_comp == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = ST_C2;
                    end
                end else begin
                    n_n     = mid;
                    mul_a   = MUL_W'(k);
                    mul_b   = MUL_W'(k);
                    n_state = ST_K2;
                end
            end
            ST_K2: begin
                n_kk    = mul_p[KK_W-1:0];
                mul_a   = MUL_W'(mul_p[KK_W-1:0]);
                mul_b   = MUL_W'(r_dsel[DLO_W-1:0]);
                n_state = ST_KL;
            end
            ST_KL: begin
                n_plo   = mul_p[PART_W-1:0];
                mul_a   = MUL_W'(r_kk);
                mul_b   = MUL_W'(r_dsel[DIST_W-1:DLO_W]);
                n_state = ST_KH;
            end
            ST_KH: begin
                if (prod <= r_rhs) begin
                    n_lo = r_n;
                end else begin
                    n_hi = r_n - MAG_W'(1);
                end
                n_state = ST_IT;
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = r_last ? ST_IDLE : ST_SEL0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_nmatch <= '0;
            r_match  <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_nmatch <= n_nmatch;
            r_match  <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_oz     <= n_oz;
        r_rad    <= n_rad;
        r_c      <= n_c;
        r_neg    <= n_neg;
        r_acc    <= n_acc;
        r_best_v <= n_best_v;
        r_best   <= n_best;
        r_best_d <= n_best_d;
        r_dsel   <= n_dsel;
        r_slot   <= n_slot;
        r_found  <= n_found;
        r_last   <= n_last;
        r_comp   <= n_comp;
        r_dir    <= n_dir;
        r_rhs    <= n_rhs;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_n      <= n_n;
        r_kk     <= n_kk;
        r_plo    <= n_plo;
    end

    assign o_valid   = (r_state == ST_OUT);
    assign o_found   = r_found;
    assign o_slot    = SLOT_W'(r_slot);
    assign o_dist_sq = r_dsel;
    assign o_dir_x   = r_dir[0];
    assign o_dir_y   = r_dir[1];
    assign o_dir_z   = r_dir[2];
    assign o_last    = r_last;
endmodule

### rtl/rfsn_checker.sv
// Port-level checks for the neighbor search top level, plus the bind.
// Depends on rfsn_pkg and radius_filter_sorted_neighbors_top.
module rfsn_checker
    import rfsn_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic                    o_found,
    input logic                    o_last,
    input logic [DIST_W-1:0]       o_dist_sq,
    input logic signed [DIR_W-1:0] o_dir_x
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dist_sq) && $stable(o_last))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while a result is pending");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last && (o_dist_sq == '0) && (o_dir_x == '0))
        else $error("empty result malformed");

    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir_x <= DIR_W'(UNIT)) && (o_dir_x >= -DIR_W'(UNIT)))
        else $error("direction out of range");
endmodule

bind radius_filter_sorted_neighbors_top rfsn_checker u_rfsn_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_found   (o_found),
    .o_last    (o_last),
    .o_dist_sq (o_dist_sq),
    .o_dir_x   (o_dir_x)
);

### tb/rfsn_neighbor_checker.sv
// Checker for the radius filter neighbor search: watches both channels, keeps a
// copy of the point list, predicts every query result and compares. Needs rfsn_pkg.
module rfsn_neighbor_checker
    import rfsn_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_ready_in,
    input  logic [CMD_W-1:0]          i_command,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic                      i_present,
    input  logic [DIST_W-1:0]         i_radius_sq,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_found,
    input  logic [SLOT_W-1:0]         i_slot,
    input  logic [DIST_W-1:0]         i_dist_sq,
    input  logic signed [DIR_W-1:0]   i_dir_x,
    input  logic signed [DIR_W-1:0]   i_dir_y,
    input  logic signed [DIR_W-1:0]   i_dir_z,
    input  logic                      i_last,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [DIST_W-1:0] dist_sq;
        logic [DIR_W-1:0]  dir_x;
        logic [DIR_W-1:0]  dir_y;
        logic [DIR_W-1:0]  dir_z;
        logic              last;
    } t_neighbor_hit;

    t_neighbor_hit              expected_hits[$];
    logic signed [COORD_W-1:0]  pt_x[ENTRIES];
    logic signed [COORD_W-1:0]  pt_y[ENTRIES];
    logic signed [COORD_W-1:0]  pt_z[ENTRIES];
    logic                       pt_present[ENTRIES];
    int                         stored_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Round 16384*|diff|/sqrt(d) by bisection on exact integer squares.
    function automatic logic [DIR_W-1:0] unit_component(longint diff, longint unsigned d);
        longint unsigned c, lo, hi, n, k;
        logic [127:0]    lhs, rhs;
        if (d == 0) return '0;
        c   = (diff < 0) ? longint'(-diff) : longint'(diff);
        rhs = 128'(c * c) << RHS_SH;
        lo  = 0;
        hi  = UNIT;
        while (lo < hi) begin
            n   = (lo + hi + 1) >> 1;
            k   = 2 * n - 1;
            lhs = 128'(k * k) * 128'(d);
            if (lhs <= rhs) lo = n;
            else hi = n - 1;
        end
        return (diff < 0) ? DIR_W'(-lo) : DIR_W'(lo);
    endfunction

    task automatic predict_neighbors(input logic signed [COORD_W-1:0] ox,
                                     input logic signed [COORD_W-1:0] oy,
                                     input logic signed [COORD_W-1:0] oz,
                                     input logic [DIST_W-1:0] rad);
        int              order[ENTRIES];
        longint unsigned match_dist[ENTRIES];
        longint          dx, dy, dz;
        longint unsigned d;
        t_neighbor_hit   h;
        int              n, j, s;
        n = 0;
        for (int i = 0; i < stored_count; i++) begin
            if (!pt_present[i]) continue;
            dx = longint'(pt_x[i]) - longint'(ox);
            dy = longint'(pt_y[i]) - longint'(oy);
            dz = longint'(pt_z[i]) - longint'(oz);
            d  = dx * dx + dy * dy + dz * dz;
            if (d > rad) continue;
            // stable insert keeps equal distances in slot order
            j = n;
            while (j > 0 && match_dist[j-1] > d) begin
                match_dist[j] = match_dist[j-1];
                order[j]      = order[j-1];
                j--;
            end
            match_dist[j] = d;
            order[j]      = i;
            n++;
        end
        if (n == 0) begin
            h = '{found: 1'b0, slot: '0, dist_sq: '0, dir_x: '0, dir_y: '0, dir_z: '0,
                  last: 1'b1};
            expected_hits.push_back(h);
        end
        for (j = 0; j < n; j++) begin
            s         = order[j];
            h.found   = 1'b1;
            h.slot    = SLOT_W'(s);
            h.dist_sq = DIST_W'(match_dist[j]);
            h.dir_x   = unit_component(longint'(pt_x[s]) - longint'(ox), match_dist[j]);
            h.dir_y   = unit_component(longint'(pt_y[s]) - longint'(oy), match_dist[j]);
            h.dir_z   = unit_component(longint'(pt_z[s]) - longint'(oz), match_dist[j]);
            h.last    = (j == n - 1);
            expected_hits.push_back(h);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_neighbor_hit h;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual slot %0d dist %0h",
                             $time, i_slot, i_dist_sq);
                    o_fail_count++;
                end else begin
                    h = expected_hits.pop_front();
                    check_field("found", h.found, i_found);
                    check_field("slot", h.slot, i_slot);
                    check_field("dist_sq", h.dist_sq, i_dist_sq);
                    check_field("dir_x", h.dir_x, $unsigned(i_dir_x));
                    check_field("dir_y", h.dir_y, $unsigned(i_dir_y));
                    check_field("dir_z", h.dir_z, $unsigned(i_dir_z));
                    check_field("last", h.last, i_last);
                    o_checked++;
                end
            end
            if (i_valid && i_ready_in) begin
                case (i_command)
                    CMD_CLEAR: stored_count = 0;
                    CMD_APPEND: begin
                        // drop appends to a full list
                        if (stored_count < ENTRIES) begin
                            pt_x[stored_count]       = i_pos_x;
                            pt_y[stored_count]       = i_pos_y;
                            pt_z[stored_count]       = i_pos_z;
                            pt_present[stored_count] = i_present;
                            stored_count++;
                        end
                    end
                    CMD_QUERY: predict_neighbors(i_pos_x, i_pos_y, i_pos_z, i_radius_sq);
                    default: ;
                endcase
            end
            o_pending = expected_hits.size();
        end
    end

endmodule

### tb/tb_radius_filter_sorted_neighbors_top.sv
// Testbench top for the radius filter neighbor search: clock, reset, stimulus
// and verdict. Depends on rfsn_pkg, the block and rfsn_neighbor_checker.
module tb_radius_filter_sorted_neighbors_top;
    import rfsn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 420;
    localparam int STALL_LIMIT = 20000;
    localparam logic [DIST_W-1:0] RAD_MAX = '1;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [CMD_W-1:0]          i_command = CMD_CLEAR;
    logic signed [COORD_W-1:0] i_pos_x = '0;
    logic signed [COORD_W-1:0] i_pos_y = '0;
    logic signed [COORD_W-1:0] i_pos_z = '0;
    logic                      i_present = 1'b0;
    logic [DIST_W-1:0]         i_radius_sq = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_found;
    logic [SLOT_W-1:0]         o_slot;
    logic [DIST_W-1:0]         o_dist_sq;
    logic signed [DIR_W-1:0]   o_dir_x;
    logic signed [DIR_W-1:0]   o_dir_y;
    logic signed [DIR_W-1:0]   o_dir_z;
    logic                      o_last;

    int fail_count, pending_hits, checked_hits;
    int send_idle_pct = 12;
    int recv_idle_pct = 71;
    int items_sent = 0;
    int queries_sent = 0;
    int stall_cycles = 0;

    // mirror of appended points, used to aim radii at exact distances
    logic signed [COORD_W-1:0] aim_x[ENTRIES], aim_y[ENTRIES], aim_z[ENTRIES];
    int aim_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    radius_filter_sorted_neighbors_top i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_pos_x, .i_pos_y, .i_pos_z,
        .i_present, .i_radius_sq, .o_valid, .i_ready, .o_found, .o_slot, .o_dist_sq,
        .o_dir_x, .o_dir_y, .o_dir_z, .o_last
    );

    rfsn_neighbor_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_command, .i_pos_x, .i_pos_y,
        .i_pos_z, .i_present, .i_radius_sq, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_found(o_found), .i_slot(o_slot), .i_dist_sq(o_dist_sq), .i_dir_x(o_dir_x),
        .i_dir_y(o_dir_y), .i_dir_z(o_dir_z), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending_hits), .o_checked(checked_hits)
    );

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input t_cmd cmd, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z,
                             input logic pres, input logic [DIST_W-1:0] rad);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_pos_x     <= x;
        i_pos_y     <= y;
        i_pos_z     <= z;
        i_present   <= pres;
        i_radius_sq <= rad;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if (cmd == CMD_CLEAR) aim_count = 0;
        if (cmd == CMD_APPEND && aim_count < ENTRIES) begin
            aim_x[aim_count] = x;
            aim_y[aim_count] = y;
            aim_z[aim_count] = z;
            aim_count++;
        end
        if (cmd == CMD_QUERY) queries_sent++;
        items_sent++;
        if (items_sent == ITEM_TARGET / 3) begin
            send_idle_pct = 71;
            recv_idle_pct = 12;
        end else if (items_sent == 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        return COORD_W'($urandom);
    endfunction

    function automatic logic [DIST_W-1:0] rand_radius();
        return {10'($urandom), 32'($urandom)};
    endfunction

    // Point near a center, offset by -64 to +64 on each axis.
    function automatic logic signed [COORD_W-1:0] near_coord(
            input logic signed [COORD_W-1:0] c);
        return COORD_W'(c + $signed(COORD_W'($urandom_range(128))) - COORD_W'(64));
    endfunction

    task automatic run_sequence();
        logic signed [COORD_W-1:0] cx, cy, cz, ox, oy, oz;
        logic [DIST_W-1:0]         rad;
        longint                    dx, dy, dz;
        int                        n_pts, n_q, spread, k;
        spread = ($urandom_range(1) == 1) ? 64 : 0;
        cx = rand_coord() >>> 1;
        cy = rand_coord() >>> 1;
        cz = rand_coord() >>> 1;
        send_item(CMD_CLEAR, rand_coord(), rand_coord(), rand_coord(), 1'($urandom),
                  rand_radius());
        n_pts = ($urandom_range(9) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 6);
        for (int i = 0; i < n_pts; i++) begin
            if (spread != 0 && $urandom_range(5) == 0 && aim_count > 0) begin
                // duplicate an earlier point to force a distance tie
                k = $urandom_range(aim_count - 1);
                send_item(CMD_APPEND, aim_x[k], aim_y[k], aim_z[k], 1'b1, rand_radius());
            end else if (spread != 0) begin
                send_item(CMD_APPEND, near_coord(cx), near_coord(cy), near_coord(cz),
                          ($urandom_range(99) < 85), rand_radius());
            end else begin
                send_item(CMD_APPEND, rand_coord(), rand_coord(), rand_coord(),
                          ($urandom_range(99) < 85), rand_radius());
            end
        end
        n_q = $urandom_range(1, 3);
        for (int q = 0; q < n_q; q++) begin
            if (spread != 0) begin
                ox = near_coord(cx);
                oy = near_coord(cy);
                oz = near_coord(cz);
            end else begin
                ox = rand_coord();
                oy = rand_coord();
                oz = rand_coord();
            end
            case ($urandom_range(3))
                0: rad = RAD_MAX;
                1: rad = rand_radius();
                2: rad = DIST_W'($urandom_range(3 * 128 * 128));
                default: begin
                    // land the limit exactly on a stored point's distance
                    rad = rand_radius();
                    if (aim_count > 0) begin
                        k  = $urandom_range(aim_count - 1);
                        dx = longint'(aim_x[k]) - longint'(ox);
                        dy = longint'(aim_y[k]) - longint'(oy);
                        dz = longint'(aim_z[k]) - longint'(oz);
                        rad = DIST_W'(dx * dx + dy * dy + dz * dz);
                    end
                end
            endcase
            send_item(CMD_QUERY, ox, oy, oz, 1'($urandom), rad);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list, extremes, null entry, tie, zero vector, unused command
        send_item(CMD_QUERY, '0, '0, '0, 1'b0, RAD_MAX);
        send_item(CMD_APPEND, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b1, '0);
        send_item(CMD_APPEND, 20'sh80000, 20'sh80000, 20'sh80000, 1'b1, '0);
        send_item(CMD_APPEND, 20'sd5, -20'sd7, 20'sd9, 1'b0, '0);
        send_item(CMD_APPEND, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b1, '0);
        send_item(CMD_APPEND, '0, '0, '0, 1'b1, '0);
        send_item(CMD_APPEND, 20'sd3, -20'sd4, 20'sd0, 1'b1, '0);
        send_item(CMD_NONE, 20'sd1, 20'sd1, 20'sd1, 1'b1, RAD_MAX);
        send_item(CMD_QUERY, '0, '0, '0, 1'b1, RAD_MAX);
        send_item(CMD_QUERY, 20'sh80000, 20'sh80000, 20'sh80000, 1'b0, RAD_MAX);
        send_item(CMD_QUERY, 20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b0, '0);
        send_item(CMD_QUERY, '0, '0, '0, 1'b0, '0);
        send_item(CMD_QUERY, 20'sd1, 20'sd2, 20'sd3, 1'b0, '0);
        send_item(CMD_QUERY, '0, '0, '0, 1'b0, 42'd25);
        send_item(CMD_CLEAR, '0, '0, '0, 1'b0, '0);
        send_item(CMD_QUERY, '0, '0, '0, 1'b0, RAD_MAX);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(9) == 0) begin
                send_item(t_cmd'($urandom_range(3)), rand_coord(), rand_coord(),
                          rand_coord(), 1'($urandom), rand_radius());
            end else begin
                run_sequence();
            end
        end
        i_valid <= 1'b0;

        while (pending_hits != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Sent %0d items including %0d queries; %0d results checked.",
                 items_sent, queries_sent, checked_hits);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
